// ----- rtl/sfr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg - shared types and constants for the stream find/replace core
// Widths, register map, config struct, sequencer states and a pattern byte
// picker.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int SEARCH_MAX_DEF  = 8;
  localparam int REPLACE_MAX_DEF = 8;

  localparam int BYTE_W     = 8;
  localparam int PAT_W      = 64;
  localparam int LEN_W      = 4;
  localparam int PAT_IDX_W  = 3;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 64;

  // register map, 8-byte stride
  typedef enum logic [1:0] {
    REG_SEARCH_PAT,
    REG_SEARCH_LEN,
    REG_REPLACE_PAT,
    REG_REPLACE_LEN
  } cfg_reg_t;

  // Saturated, ready-to-use configuration
  typedef struct packed {
    logic [PAT_W-1:0] search_pat;
    logic [LEN_W-1:0] search_len;
    logic [PAT_W-1:0] replace_pat;
    logic [LEN_W-1:0] replace_len;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DRAIN,
    S_FLUSH,
    S_REPL,
    S_MARK
  } state_t;

  function automatic logic [BYTE_W-1:0] pat_byte(input logic [PAT_W-1:0] w,
                                                 input logic [PAT_IDX_W-1:0] i);
    return w[i*BYTE_W +: BYTE_W];
  endfunction

endpackage

// ----- rtl/stream_find_replace_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_find_replace_core - streaming find and replace-all over bytes
// Replaces each leftmost, non-overlapping hit of the search pattern.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one subject byte per transfer, in_tlast on the final byte.
//   out_* : one result byte per transfer; out_tuser=1 carries a byte,
//           out_tuser=0 is a bare end marker. out_tlast marks the last
//           result of the stream (always sent once per in_tlast).
//   cfg_* : APB writes, 8-byte stride: search pattern, search length,
//           replacement, replacement length. Write only while idle.
// Timing: a byte is taken only in the idle state. It is written into the
//   window (a row of byte cells) and judged in the next cycle; then each
//   result byte is sent as the window shifts down one cell or the
//   replacement index steps, whenever the output register is free. A
//   closing check follows whenever the byte neither completes a hit nor
//   ends the subject.
// Stall: results sit in a single output register; while it is held and a
//   result is due, the sequencer waits and no new byte is taken.
// Reset: window empty, registers zero (search length zero = pass-through).
// ----------------------------------------------------------------------------
module stream_find_replace_core #(
  parameter int SEARCH_MAX  = sfr_pkg::SEARCH_MAX_DEF,
  parameter int REPLACE_MAX = sfr_pkg::REPLACE_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // subject stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] in_byte
  input  logic                           in_tlast,   // end_of_subject
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [7:0] out_byte
  output logic                           out_tuser,  // [0] byte_present
  output logic                           out_tlast,  // end_of_result
  // configuration
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [sfr_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [sfr_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import sfr_pkg::*;

  localparam int CNT_W = $clog2(SEARCH_MAX + 1);

  cfg_t                 cfg;
  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [PAT_IDX_W-1:0] idx_r, idx_nxt;
  logic                 end_r, end_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]    out_byte_r, out_byte_nxt;
  logic                 out_pres_r, out_pres_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [BYTE_W-1:0]    cell_byte [SEARCH_MAX];
  logic [SEARCH_MAX-1:0] cell_match, cell_ok;

  logic accept, out_free;
  logic all_ok, full_hit, prefix_hold, rep_last_idx;
  logic emit, emit_pres, emit_last, shift_en, clear_win, idx_inc;
  logic [BYTE_W-1:0] emit_byte;
  logic [LEN_W-1:0]  count_ext;

  sfr_cfg #(
    .SEARCH_MAX  (SEARCH_MAX),
    .REPLACE_MAX (REPLACE_MAX)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  assign accept   = in_tvalid & in_tready;
  assign out_free = ~out_valid_r | out_tready;

  // Window: cell 0 is the oldest pending byte; a shift hands each byte
  // one cell down, so cell i is always compared with pattern byte i.
  for (genvar i = 0; i < SEARCH_MAX; i++) begin : g_cell
    logic [BYTE_W-1:0] nbr;
    if (i == SEARCH_MAX - 1) begin : g_top
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_byte[i+1];
    end

    sfr_cell u_cell (
      .clk        (clk),
      .load_en    (accept && (count_r == CNT_W'(i))),
      .shift_en   (shift_en),
      .new_byte   (in_tdata),
      .nbr_byte   (nbr),
      .pat_byte_i (cfg.search_pat[i*BYTE_W +: BYTE_W]),
      .byte_q     (cell_byte[i]),
      .match      (cell_match[i])
    );

    // empty cells do not spoil the prefix test
    assign cell_ok[i] = (CNT_W'(i) >= count_r) || cell_match[i];
  end

  assign all_ok      = &cell_ok;
  assign count_ext   = LEN_W'(count_r);
  // whole window equals the pattern
  assign full_hit    = (cfg.search_len != '0) && (count_ext == cfg.search_len) && all_ok;
  // remaining bytes still a proper prefix: keep them waiting
  assign prefix_hold = (count_ext < cfg.search_len) && all_ok;
  assign rep_last_idx = ((LEN_W'(idx_r) + LEN_W'(1)) == cfg.replace_len);

  assign in_tready = (state_r == S_IDLE);

  // ---- next state ----
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (full_hit) begin
          if (cfg.replace_len != '0) state_nxt = S_REPL;
          else if (end_r)            state_nxt = S_MARK;
          else                       state_nxt = S_IDLE;
        end else if (end_r) begin
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (count_r == '0 || prefix_hold) state_nxt = S_IDLE;
      end
      S_FLUSH: begin
        if (count_r == '0 || (out_free && count_r == CNT_W'(1))) state_nxt = S_IDLE;
      end
      S_REPL: begin
        if (out_free && rep_last_idx) state_nxt = S_IDLE;
      end
      S_MARK: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---- sequencer outputs ----
  always_comb begin
    emit      = 1'b0;
    emit_byte = '0;
    emit_pres = 1'b1;
    emit_last = 1'b0;
    shift_en  = 1'b0;
    clear_win = 1'b0;
    idx_inc   = 1'b0;
    case (state_r)
      S_EVAL: begin
        clear_win = full_hit;
      end
      S_DRAIN: begin
        if (!(count_r == '0 || prefix_hold) && out_free) begin
          emit      = 1'b1;
          emit_byte = cell_byte[0];
          shift_en  = 1'b1;
        end
      end
      S_FLUSH: begin
        if (count_r != '0 && out_free) begin
          emit      = 1'b1;
          emit_byte = cell_byte[0];
          emit_last = (count_r == CNT_W'(1));
          shift_en  = 1'b1;
        end
      end
      S_REPL: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = pat_byte(cfg.replace_pat, idx_r);
          emit_last = end_r && rep_last_idx;
          idx_inc   = 1'b1;
        end
      end
      S_MARK: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_pres = 1'b0;
          emit_last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---- counters, flags and output register ----
  always_comb begin
    count_nxt = count_r;
    if (accept)         count_nxt = count_r + CNT_W'(1);
    else if (clear_win) count_nxt = '0;
    else if (shift_en)  count_nxt = count_r - CNT_W'(1);

    idx_nxt = idx_r;
    if (state_r == S_EVAL) idx_nxt = '0;
    else if (idx_inc)      idx_nxt = idx_r + PAT_IDX_W'(1);

    end_nxt = accept ? in_tlast : end_r;

    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_pres_nxt  = out_pres_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = emit_byte;
      out_pres_nxt  = emit_pres;
      out_last_nxt  = emit_last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      end_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      end_r       <= end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_pres_r <= out_pres_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_pres_r;
  assign out_tlast  = out_last_r;

  // ---- assertions ----
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SEARCH_MAX))
    else $error("window count beyond cell row");

  a_idle_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (count_r < CNT_W'(SEARCH_MAX)))
    else $error("idle with no free cell for the next byte");

  a_repl_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REPL) |-> (count_r == '0))
    else $error("replacement sent while window not cleared");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_last) |=> (state_r == S_IDLE && count_r == '0))
    else $error("final result sent but window not empty");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !emit)
    else $error("output register overwritten while stalled");

endmodule

// ----- rtl/sfr_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_cell - one byte of the pending window
// Loads a new byte or takes its upper neighbour's byte; flags a pattern hit.
// ----------------------------------------------------------------------------
module sfr_cell (
  input  logic                       clk,
  input  logic                       load_en,
  input  logic                       shift_en,
  input  logic [sfr_pkg::BYTE_W-1:0] new_byte,
  input  logic [sfr_pkg::BYTE_W-1:0] nbr_byte,
  input  logic [sfr_pkg::BYTE_W-1:0] pat_byte_i,
  output logic [sfr_pkg::BYTE_W-1:0] byte_q,
  output logic                       match
);
  import sfr_pkg::*;

  logic [BYTE_W-1:0] byte_r;

  always_ff @(posedge clk) begin
    if (load_en) begin
      byte_r <= new_byte;
    end else if (shift_en) begin
      byte_r <= nbr_byte;
    end
  end

  assign byte_q = byte_r;
  assign match  = (byte_r == pat_byte_i);

endmodule

// ----- rtl/sfr_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_cfg - APB register bank
// Holds patterns and lengths; lengths are saturated on the way out.
// ----------------------------------------------------------------------------
module sfr_cfg #(
  parameter int SEARCH_MAX  = sfr_pkg::SEARCH_MAX_DEF,
  parameter int REPLACE_MAX = sfr_pkg::REPLACE_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [sfr_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [sfr_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready,
  output sfr_pkg::cfg_t                  cfg
);
  import sfr_pkg::*;

  logic [PAT_W-1:0] spat_r, rpat_r;
  logic [LEN_W-1:0] slen_r, rlen_r;
  cfg_reg_t         reg_sel;
  logic             wr_en;

  assign reg_sel    = cfg_reg_t'(cfg_paddr[CFG_ADDR_W-1 -: 2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spat_r <= '0;
      slen_r <= '0;
      rpat_r <= '0;
      rlen_r <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_SEARCH_PAT:  spat_r <= cfg_pwdata[PAT_W-1:0];
        REG_SEARCH_LEN:  slen_r <= cfg_pwdata[LEN_W-1:0];
        REG_REPLACE_PAT: rpat_r <= cfg_pwdata[PAT_W-1:0];
        REG_REPLACE_LEN: rlen_r <= cfg_pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SEARCH_PAT:  cfg_prdata = CFG_DATA_W'(spat_r);
      REG_SEARCH_LEN:  cfg_prdata = CFG_DATA_W'(slen_r);
      REG_REPLACE_PAT: cfg_prdata = CFG_DATA_W'(rpat_r);
      REG_REPLACE_LEN: cfg_prdata = CFG_DATA_W'(rlen_r);
      default:         cfg_prdata = '0;
    endcase
  end

  always_comb begin
    cfg.search_pat  = spat_r;
    cfg.replace_pat = rpat_r;
    cfg.search_len  = (slen_r > LEN_W'(SEARCH_MAX))  ? LEN_W'(SEARCH_MAX)  : slen_r;
    cfg.replace_len = (rlen_r > LEN_W'(REPLACE_MAX)) ? LEN_W'(REPLACE_MAX) : rlen_r;
  end

endmodule

// ----- verif/stream_find_replace_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_find_replace_core_tb - self-checking bench for the find/replace core
// Streams subject bytes through the core under a range of search and
// replacement settings. A behavioural copy of the replace-all rule predicts
// every result transfer, and each one is checked field by field in order.
// ----------------------------------------------------------------------------
module stream_find_replace_core_tb;

  import sfr_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 11;
  localparam int RANDOM_ITEMS   = 344;
  localparam int CALM_FROM      = 280;   // no idling after this many random bytes
  localparam int DRAIN_CYCLES   = 24;    // longer than the worst per-byte latency
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTS     = 30;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } subject_byte_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              present;
    logic              last;
  } result_byte_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata    = '0;
  logic                  in_tlast    = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [7:0]            out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  stream_find_replace_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #CLK_HALF clk = ~clk;

  // --------------------------------------------------------------------------
  // Behavioural copy of the core: registers as written, plus the held window
  // --------------------------------------------------------------------------
  logic [PAT_W-1:0]  srch_pat = '0;
  logic [LEN_W-1:0]  srch_len = '0;
  logic [PAT_W-1:0]  repl_pat = '0;
  logic [LEN_W-1:0]  repl_len = '0;
  logic [BYTE_W-1:0] held_bytes [0:SEARCH_MAX_DEF-1];
  int                held_count = 0;

  subject_byte_t subject_q [$];       // bytes waiting to be sent
  result_byte_t  replaced_q [$];      // result transfers still owed by the core

  int  mismatch_count = 0;
  int  random_sent    = 0;
  bit  idle_en        = 1'b1;

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_PRINTS)
      $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // does b[from +: len] equal the head of the search pattern?
  function automatic bit head_of_pattern(input logic [BYTE_W-1:0] b [0:SEARCH_MAX_DEF],
                                         input int from, input int len);
    for (int i = 0; i < len; i++)
      if (b[from + i] != srch_pat[i*BYTE_W +: BYTE_W])
        return 1'b0;
    return 1'b1;
  endfunction

  // One accepted subject byte: work out the result transfers it causes
  task automatic find_replace_step(input logic [BYTE_W-1:0] data, input logic last);
    logic [BYTE_W-1:0] win [0:SEARCH_MAX_DEF];
    result_byte_t      burst [0:2*SEARCH_MAX_DEF];
    int                slen, rlen, n, start, produced;
    slen = (srch_len > SEARCH_MAX_DEF) ? SEARCH_MAX_DEF : int'(srch_len);
    rlen = (repl_len > REPLACE_MAX_DEF) ? REPLACE_MAX_DEF : int'(repl_len);
    for (int i = 0; i < held_count; i++)
      win[i] = held_bytes[i];
    win[held_count] = data;
    n        = held_count + 1;
    start    = 0;
    produced = 0;

    if (slen > 0 && n == slen && head_of_pattern(win, 0, n)) begin
      // whole window plus this byte is a hit
      for (int i = 0; i < rlen; i++) begin
        burst[produced] = '{repl_pat[i*BYTE_W +: BYTE_W], 1'b1, 1'b0};
        produced++;
      end
      start = n;
    end else begin
      // release from the front until what is left could still grow into a hit
      while (start < n && !((n - start) < slen && head_of_pattern(win, start, n - start))) begin
        burst[produced] = '{win[start], 1'b1, 1'b0};
        produced++;
        start++;
      end
    end

    if (last) begin
      while (start < n) begin
        burst[produced] = '{win[start], 1'b1, 1'b0};
        produced++;
        start++;
      end
      // deleted final match: bare end marker
      if (produced == 0) begin
        burst[0] = '{8'h00, 1'b0, 1'b0};
        produced = 1;
      end
      burst[produced-1].last = 1'b1;
    end

    held_count = n - start;
    for (int i = 0; i < held_count; i++)
      held_bytes[i] = win[start + i];
    for (int i = 0; i < produced; i++)
      replaced_q.push_back(burst[i]);
  endtask

  // --------------------------------------------------------------------------
  // Subject driver: feeds from subject_q, random gap bursts, prediction on
  // every accepted transfer
  // --------------------------------------------------------------------------
  int send_gap = 0;

  always @(posedge clk) begin : subject_driver
    subject_byte_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap  <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid)
        find_replace_step(in_tdata, in_tlast);
      if (send_gap != 0) begin
        in_tvalid <= 1'b0;
        send_gap  <= send_gap - 1;
      end else if (subject_q.size() != 0) begin
        if (idle_en && $urandom_range(0, 5) == 0) begin
          in_tvalid <= 1'b0;
          send_gap  <= $urandom_range(0, 10);
        end else begin
          nxt = subject_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.data;
          in_tlast  <= nxt.last;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: random back-pressure bursts, in-order field check
  // --------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin : result_monitor
    result_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (replaced_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer data=%02h user=%0b last=%0b",
                                  out_tdata, out_tuser, out_tlast));
      end else begin
        want = replaced_q.pop_front();
        if (out_tdata !== want.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", out_tdata, want.data));
        if (out_tuser !== want.present)
          report_mismatch($sformatf("byte_present %0b, want %0b", out_tuser, want.present));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("end_of_result %0b, want %0b", out_tlast, want.last));
      end
    end

    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long with no transfer on any port
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no transfer for %0d cycles, %0d results outstanding",
               $realtime, quiet_cycles, replaced_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // APB write: setup then access; the copy is updated at the access edge
  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_SEARCH_PAT:  srch_pat = value;
      REG_SEARCH_LEN:  srch_len = value[LEN_W-1:0];
      REG_REPLACE_PAT: repl_pat = value;
      REG_REPLACE_LEN: repl_len = value[LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [PAT_W-1:0] spat, input logic [LEN_W-1:0] slen,
                            input logic [PAT_W-1:0] rpat, input logic [LEN_W-1:0] rlen);
    cfg_write(REG_SEARCH_PAT,  spat);
    cfg_write(REG_SEARCH_LEN,  CFG_DATA_W'(slen));
    cfg_write(REG_REPLACE_PAT, rpat);
    cfg_write(REG_REPLACE_LEN, CFG_DATA_W'(rlen));
    @(negedge clk);
  endtask

  // sampled on falling edges so it never races the clocked blocks;
  // the trailing wait covers bytes still being judged with no result owed
  task automatic wait_idle();
    do @(negedge clk);
    while (subject_q.size() != 0 || in_tvalid || replaced_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send(input logic [BYTE_W-1:0] data, input logic last);
    subject_q.push_back('{data, last});
  endtask

  // one subject: runs of the search pattern mixed with near-miss and random bytes
  task automatic queue_subject(input int len, input bit close, input logic [7:0] alpha);
    int k, sel, run, pat_n;
    pat_n = (srch_len == 0 || srch_len > SEARCH_MAX_DEF) ? SEARCH_MAX_DEF : int'(srch_len);
    k = 0;
    while (k < len) begin
      sel = $urandom_range(0, 19);
      if (sel < 10) begin
        run = (sel < 6) ? pat_n : $urandom_range(1, pat_n);
        for (int j = 0; j < run && k < len; j++) begin
          send(srch_pat[j*BYTE_W +: BYTE_W], close && k == len - 1);
          k++;
        end
      end else begin
        if (sel < 17)
          send(alpha + 8'($urandom_range(0, 2)), close && k == len - 1);
        else
          send(8'($urandom_range(0, 255)), close && k == len - 1);
        k++;
      end
    end
  endtask

  task automatic random_phase();
    logic [PAT_W-1:0] spat;
    logic [LEN_W-1:0] slen, rlen;
    logic [7:0]       alpha;
    int               target, len, done;
    bit               closing;
    idle_en = (random_sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
    alpha   = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 4) == 0) begin
      spat = {$urandom, $urandom};
    end else begin
      for (int i = 0; i < SEARCH_MAX_DEF; i++)
        spat[i*BYTE_W +: BYTE_W] = alpha + 8'($urandom_range(0, 2));
    end
    case ($urandom_range(0, 11))
      0:       slen = 4'd0;
      1:       slen = LEN_W'($urandom_range(9, 15));
      default: slen = LEN_W'($urandom_range(1, 8));
    endcase
    rlen = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(9, 15))
                                       : LEN_W'($urandom_range(0, 8));
    set_config(spat, slen, {$urandom, $urandom}, rlen);

    target  = $urandom_range(15, 45);
    if (target > RANDOM_ITEMS - random_sent)
      target = RANDOM_ITEMS - random_sent;
    closing = (random_sent + target >= RANDOM_ITEMS);
    done    = 0;
    while (done < target) begin
      len = $urandom_range(1, 16);
      if (len > target - done)
        len = target - done;
      // the phase may end mid-subject so the next setting meets a held window
      queue_subject(len, (done + len < target) || closing || $urandom_range(0, 3) != 0,
                    alpha);
      done += len;
    end
    random_sent += target;
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: zero search length, bytes pass straight through
    @(negedge clk);
    send(8'h00, 1'b0);
    send(8'hFF, 1'b1);
    wait_idle();

    // "ABA" becomes two all-ones bytes; trailing held byte flushed at the end
    set_config(64'h0000_0000_0041_4241, 4'd3, 64'hFFFF_FFFF_FFFF_FFFF, 4'd2);
    send(8'h41, 1'b0);
    send(8'h42, 1'b0);
    send(8'h41, 1'b0);
    send(8'h41, 1'b1);
    wait_idle();

    // deletion; a deleted final match leaves only a bare end marker
    set_config(64'h0000_0000_0000_005A, 4'd1, 64'h0, 4'd0);
    send(8'h5A, 1'b0);
    send(8'h5A, 1'b1);
    wait_idle();

    // both lengths above the maximum saturate to eight bytes
    set_config(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 64'h0011_2233_4455_6677, 4'd15);
    for (int i = 0; i < 8; i++)
      send(8'hFF, 1'b0);
    send(8'h00, 1'b1);
    wait_idle();

    // hold six bytes, then change the search mid-subject: the hit lying
    // inside the carried window goes out unreplaced
    @(negedge clk);
    for (int i = 0; i < 6; i++)
      send(8'hFF, 1'b0);
    wait_idle();
    set_config(64'h0000_0000_0000_FFFF, 4'd2, 64'h0000_0000_0000_00A5, 4'd1);
    send(8'h00, 1'b0);
    send(8'hFF, 1'b0);
    send(8'hFF, 1'b1);
    wait_idle();

    while (random_sent < RANDOM_ITEMS)
      random_phase();

    wait_idle();
    if (mismatch_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- stream_find_replace_core.f -----
rtl/sfr_pkg.sv
rtl/sfr_cell.sv
rtl/sfr_cfg.sv
rtl/stream_find_replace_core.sv
verif/stream_find_replace_core_tb.sv
